### src/r2fft_pkg.sv
package r2fft_pkg;

   localparam int INDEX_BITS = 10;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_RUN  = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_DATA,
      ST_RD_OUT,
      ST_REV_ADDR,
      ST_REV_READ,
      ST_REV_WA,
      ST_REV_WB,
      ST_BF_ADDR,
      ST_BF_READ,
      ST_BF_MUL,
      ST_BF_SUM,
      ST_BF_WA,
      ST_BF_WB,
      ST_DONE_OUT
   } eng_state_type;

   // head of the command queue as seen by the engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } job_ctrl_type;

   // engine to result queue
   typedef struct packed {
      logic push;
      logic is_done;
   } rsp_ctrl_type;

endpackage

### src/r2fft_front.sv
module r2fft_front #(
   parameter int INPUT_BITS = 16,
   parameter int ADDR_BITS  = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [1:0]                            req_cmd,
   input  logic [r2fft_pkg::INDEX_BITS-1:0]      req_index,
   input  logic signed [INPUT_BITS-1:0]          req_sample_real,
   input  logic signed [INPUT_BITS-1:0]          req_sample_imag,
   output r2fft_pkg::job_ctrl_type               job_ctrl,
   output logic [ADDR_BITS-1:0]                  job_addr,
   output logic signed [INPUT_BITS-1:0]          job_real,
   output logic signed [INPUT_BITS-1:0]          job_imag,
   input  logic                                  job_pop
);

   r2fft_pkg::cmd_type              cmd_ff  [2];
   logic [ADDR_BITS-1:0]            addr_ff [2];
   logic signed [INPUT_BITS-1:0]    re_ff   [2];
   logic signed [INPUT_BITS-1:0]    im_ff   [2];
   logic                            wr_ptr_ff, wr_ptr_in;
   logic                            rd_ptr_ff, rd_ptr_in;
   logic [1:0]                      count_ff, count_in;
   logic                            known_cmd;
   logic                            store;
   logic                            take;

   // unused command code is accepted and dropped here
   assign known_cmd = (req_cmd == r2fft_pkg::CMD_LOAD) || (req_cmd == r2fft_pkg::CMD_RUN) ||
                      (req_cmd == r2fft_pkg::CMD_READ);
   assign req_full  = (count_ff == 2'd2);
   assign store     = req_push && !req_full && known_cmd;
   assign take      = job_pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = store ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, store} - {1'b0, take};
   end

   assign job_ctrl.valid = (count_ff != 2'd0);
   assign job_ctrl.cmd   = cmd_ff[rd_ptr_ff];
   assign job_addr       = addr_ff[rd_ptr_ff];
   assign job_real       = re_ff[rd_ptr_ff];
   assign job_imag       = im_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         cmd_ff[wr_ptr_ff]  <= r2fft_pkg::cmd_type'(req_cmd);
         addr_ff[wr_ptr_ff] <= ADDR_BITS'(req_index);
         re_ff[wr_ptr_ff]   <= req_sample_real;
         im_ff[wr_ptr_ff]   <= req_sample_imag;
      end
   end

endmodule

### src/r2fft_outq.sv
module r2fft_outq #(
   parameter int WORK_BITS = 27
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  r2fft_pkg::rsp_ctrl_type               rsp_ctrl,
   input  logic signed [WORK_BITS-1:0]           push_real,
   input  logic signed [WORK_BITS-1:0]           push_imag,
   input  logic [r2fft_pkg::INDEX_BITS-1:0]      push_bin,
   output logic                                  out_full,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [WORK_BITS-1:0]           rsp_result_real,
   output logic signed [WORK_BITS-1:0]           rsp_result_imag,
   output logic [r2fft_pkg::INDEX_BITS-1:0]      rsp_bin_number,
   output logic                                  rsp_is_done
);

   logic signed [WORK_BITS-1:0]             re_ff   [2];
   logic signed [WORK_BITS-1:0]             im_ff   [2];
   logic [r2fft_pkg::INDEX_BITS-1:0]        bin_ff  [2];
   logic                                    done_ff [2];
   logic                                    wr_ptr_ff, wr_ptr_in;
   logic                                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]                              count_ff, count_in;
   logic                                    take;

   assign out_full  = (count_ff == 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign take      = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = rsp_ctrl.push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, rsp_ctrl.push} - {1'b0, take};
   end

   assign rsp_result_real = re_ff[rd_ptr_ff];
   assign rsp_result_imag = im_ff[rd_ptr_ff];
   assign rsp_bin_number  = bin_ff[rd_ptr_ff];
   assign rsp_is_done     = done_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ctrl.push) begin
         re_ff[wr_ptr_ff]   <= push_real;
         im_ff[wr_ptr_ff]   <= push_imag;
         bin_ff[wr_ptr_ff]  <= push_bin;
         done_ff[wr_ptr_ff] <= rsp_ctrl.is_done;
      end
   end

endmodule

### src/r2fft_engine.sv
module r2fft_engine #(
   parameter int POINTS       = 1024,
   parameter int INPUT_BITS   = 16,
   parameter int TWIDDLE_BITS = 16,
   parameter int ADDR_BITS    = 10,
   parameter int WORK_BITS    = 27
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  r2fft_pkg::job_ctrl_type               job_ctrl,
   input  logic [ADDR_BITS-1:0]                  job_addr,
   input  logic signed [INPUT_BITS-1:0]          job_real,
   input  logic signed [INPUT_BITS-1:0]          job_imag,
   output logic                                  job_pop,
   input  logic                                  out_full,
   output r2fft_pkg::rsp_ctrl_type               rsp_ctrl,
   output logic signed [WORK_BITS-1:0]           push_real,
   output logic signed [WORK_BITS-1:0]           push_imag,
   output logic [r2fft_pkg::INDEX_BITS-1:0]      push_bin
);

   localparam int    HALF      = POINTS / 2;
   localparam int    STG_BITS  = $clog2(ADDR_BITS);
   localparam int    FRAC      = TWIDDLE_BITS - 1;
   localparam int    PROD_BITS = WORK_BITS + TWIDDLE_BITS;
   localparam int    SUM_BITS  = PROD_BITS + 1;
   localparam int    MAXPOS    = (1 << FRAC) - 1;
   localparam real   PI_VAL    = 3.14159265358979323846;
   localparam real   SCALE     = 2.0 ** FRAC;
   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (FRAC - 1);

   // twiddle rom: cos and minus sin, magnitude rounded half away from zero
   logic signed [TWIDDLE_BITS-1:0] rom_cos  [HALF];
   logic signed [TWIDDLE_BITS-1:0] rom_nsin [HALF];

   for (genvar g = 0; g < HALF; g++) begin : g_rom
      localparam bit  NEG_COS = (4 * g > POINTS);
      localparam int  JJ      = NEG_COS ? (HALF - g) : g;
      localparam real ANG     = 2.0 * PI_VAL * JJ / POINTS;
      localparam int  CM0     = $rtoi($floor($cos(ANG) * SCALE + 0.5));
      localparam int  CM      = (CM0 > MAXPOS) ? MAXPOS : CM0;
      localparam int  CV      = NEG_COS ? -CM : CM;
      localparam int  SM      = $rtoi($floor($sin(ANG) * SCALE + 0.5));
      assign rom_cos[g]  = TWIDDLE_BITS'(CV);
      assign rom_nsin[g] = TWIDDLE_BITS'(-SM);
   end

   // work store, two read ports and one write port
   logic signed [WORK_BITS-1:0] mem_re [POINTS];
   logic signed [WORK_BITS-1:0] mem_im [POINTS];

   r2fft_pkg::eng_state_type    state_ff, state_in;
   logic [ADDR_BITS-1:0]        cnt_ff, cnt_in;
   logic [STG_BITS-1:0]         stage_ff, stage_in;
   logic [ADDR_BITS-1:0]        a_ff, a_in;
   logic [ADDR_BITS-1:0]        b_ff, b_in;
   logic [ADDR_BITS-2:0]        k_ff, k_in;

   logic signed [WORK_BITS-1:0]    rd_a_re_ff, rd_a_im_ff, rd_b_re_ff, rd_b_im_ff;
   logic signed [TWIDDLE_BITS-1:0] tw_re_ff, tw_im_ff;
   logic signed [PROD_BITS-1:0]    p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [WORK_BITS-1:0]    t_re_ff, t_im_ff;
   logic signed [SUM_BITS-1:0]     sum_re, sum_im;

   logic                        wr_en;
   logic [ADDR_BITS-1:0]        wr_addr;
   logic signed [WORK_BITS-1:0] wr_re, wr_im;

   logic [ADDR_BITS-1:0]        rev;
   logic [ADDR_BITS-1:0]        jx, half_bit, low_mask, bf_a, bf_b, kx;
   logic                        last_bf;
   logic                        last_stage;

   always_comb begin
      for (int i = 0; i < ADDR_BITS; i++) begin
         rev[i] = cnt_ff[ADDR_BITS-1-i];
      end
   end

   // butterfly j of stage s: a has a zero inserted at bit s, b = a + 2^s
   always_comb begin
      jx       = {1'b0, cnt_ff[ADDR_BITS-2:0]};
      half_bit = ADDR_BITS'(1) << stage_ff;
      low_mask = half_bit - ADDR_BITS'(1);
      bf_a     = ((jx & ~low_mask) << 1) | (jx & low_mask);
      bf_b     = bf_a | half_bit;
      kx       = (jx & low_mask) << (STG_BITS'(ADDR_BITS - 1) - stage_ff);
   end

   assign last_bf    = &cnt_ff[ADDR_BITS-2:0];
   assign last_stage = (stage_ff == STG_BITS'(ADDR_BITS - 1));

   always_comb begin
      sum_re = SUM_BITS'(p_rr_ff) - SUM_BITS'(p_ii_ff) + ROUND_HALF;
      sum_im = SUM_BITS'(p_ri_ff) + SUM_BITS'(p_ir_ff) + ROUND_HALF;
   end

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      stage_in          = stage_ff;
      a_in              = a_ff;
      b_in              = b_ff;
      k_in              = k_ff;
      job_pop           = 1'b0;
      wr_en             = 1'b0;
      wr_addr           = a_ff;
      wr_re             = rd_a_re_ff;
      wr_im             = rd_a_im_ff;
      rsp_ctrl.push     = 1'b0;
      rsp_ctrl.is_done  = 1'b0;
      push_real         = rd_a_re_ff;
      push_imag         = rd_a_im_ff;
      push_bin          = r2fft_pkg::INDEX_BITS'(a_ff);
      case (state_ff)
         r2fft_pkg::ST_IDLE: begin
            if (job_ctrl.valid) begin
               case (job_ctrl.cmd)
                  r2fft_pkg::CMD_LOAD: begin
                     job_pop = 1'b1;
                     wr_en   = 1'b1;
                     wr_addr = job_addr;
                     wr_re   = WORK_BITS'(job_real);
                     wr_im   = WORK_BITS'(job_imag);
                  end
                  r2fft_pkg::CMD_READ: begin
                     if (!out_full) begin
                        job_pop  = 1'b1;
                        a_in     = job_addr;
                        state_in = r2fft_pkg::ST_RD_DATA;
                     end
                  end
                  r2fft_pkg::CMD_RUN: begin
                     if (!out_full) begin
                        job_pop  = 1'b1;
                        cnt_in   = '0;
                        state_in = r2fft_pkg::ST_REV_ADDR;
                     end
                  end
                  default: begin
                     job_pop = 1'b1;
                  end
               endcase
            end
         end
         r2fft_pkg::ST_RD_DATA: begin
            state_in = r2fft_pkg::ST_RD_OUT;
         end
         r2fft_pkg::ST_RD_OUT: begin
            rsp_ctrl.push = 1'b1;
            state_in      = r2fft_pkg::ST_IDLE;
         end
         r2fft_pkg::ST_REV_ADDR: begin
            a_in = cnt_ff;
            b_in = rev;
            if (cnt_ff < rev) begin
               state_in = r2fft_pkg::ST_REV_READ;
            end else if (&cnt_ff) begin
               cnt_in   = '0;
               stage_in = '0;
               state_in = r2fft_pkg::ST_BF_ADDR;
            end else begin
               cnt_in = cnt_ff + ADDR_BITS'(1);
            end
         end
         r2fft_pkg::ST_REV_READ: begin
            state_in = r2fft_pkg::ST_REV_WA;
         end
         r2fft_pkg::ST_REV_WA: begin
            wr_en    = 1'b1;
            wr_addr  = a_ff;
            wr_re    = rd_b_re_ff;
            wr_im    = rd_b_im_ff;
            state_in = r2fft_pkg::ST_REV_WB;
         end
         r2fft_pkg::ST_REV_WB: begin
            // read registers still hold the values from before the first write
            wr_en    = 1'b1;
            wr_addr  = b_ff;
            wr_re    = rd_a_re_ff;
            wr_im    = rd_a_im_ff;
            cnt_in   = cnt_ff + ADDR_BITS'(1);
            state_in = r2fft_pkg::ST_REV_ADDR;
         end
         r2fft_pkg::ST_BF_ADDR: begin
            a_in     = bf_a;
            b_in     = bf_b;
            k_in     = kx[ADDR_BITS-2:0];
            state_in = r2fft_pkg::ST_BF_READ;
         end
         r2fft_pkg::ST_BF_READ: begin
            state_in = r2fft_pkg::ST_BF_MUL;
         end
         r2fft_pkg::ST_BF_MUL: begin
            state_in = r2fft_pkg::ST_BF_SUM;
         end
         r2fft_pkg::ST_BF_SUM: begin
            state_in = r2fft_pkg::ST_BF_WA;
         end
         r2fft_pkg::ST_BF_WA: begin
            wr_en    = 1'b1;
            wr_addr  = a_ff;
            wr_re    = rd_a_re_ff + t_re_ff;
            wr_im    = rd_a_im_ff + t_im_ff;
            state_in = r2fft_pkg::ST_BF_WB;
         end
         r2fft_pkg::ST_BF_WB: begin
            wr_en   = 1'b1;
            wr_addr = b_ff;
            wr_re   = rd_a_re_ff - t_re_ff;
            wr_im   = rd_a_im_ff - t_im_ff;
            if (last_bf) begin
               cnt_in = '0;
               if (last_stage) begin
                  state_in = r2fft_pkg::ST_DONE_OUT;
               end else begin
                  stage_in = stage_ff + STG_BITS'(1);
                  state_in = r2fft_pkg::ST_BF_ADDR;
               end
            end else begin
               cnt_in   = cnt_ff + ADDR_BITS'(1);
               state_in = r2fft_pkg::ST_BF_ADDR;
            end
         end
         r2fft_pkg::ST_DONE_OUT: begin
            rsp_ctrl.push    = 1'b1;
            rsp_ctrl.is_done = 1'b1;
            push_real        = '0;
            push_imag        = '0;
            push_bin         = '0;
            state_in         = r2fft_pkg::ST_IDLE;
         end
         default: begin
            state_in = r2fft_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= r2fft_pkg::ST_IDLE;
         cnt_ff   <= '0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_re[wr_addr] <= wr_re;
         mem_im[wr_addr] <= wr_im;
      end
      rd_a_re_ff <= mem_re[a_ff];
      rd_a_im_ff <= mem_im[a_ff];
      rd_b_re_ff <= mem_re[b_ff];
      rd_b_im_ff <= mem_im[b_ff];
   end

   always_ff @(posedge clock) begin
      tw_re_ff <= rom_cos[k_ff];
      tw_im_ff <= rom_nsin[k_ff];
   end

   // twiddle multiply, then round at the fraction point
   always_ff @(posedge clock) begin
      p_rr_ff <= rd_b_re_ff * tw_re_ff;
      p_ii_ff <= rd_b_im_ff * tw_im_ff;
      p_ri_ff <= rd_b_re_ff * tw_im_ff;
      p_ir_ff <= rd_b_im_ff * tw_re_ff;
      t_re_ff <= WORK_BITS'(sum_re >>> FRAC);
      t_im_ff <= WORK_BITS'(sum_im >>> FRAC);
   end

endmodule

### src/radix2_fft_1024_core.sv
// channel   direction  handshake             payload
// req_      in         push / full           cmd, index, sample_real, sample_imag
// rsp_      out        empty / pop           result_real, result_imag, bin_number, is_done
//
// load: written in the idle state; read: RD_DATA, RD_OUT, set by the registered store read.
// run: a bit-reverse scan of all POINTS addresses, REV_READ, REV_WA and REV_WB per swapped
//   pair, then BF_ADDR, BF_READ, BF_MUL, BF_SUM, BF_WA and BF_WB per butterfly,
//   (POINTS/2)*log2(POINTS) butterflies, one write port on the work store.
// reset clears the queues and the sequencer; the work store holds no reset value.
// a two-entry command queue takes items while the engine works; the engine waits
//   for room in the two-entry result queue before it starts a read or a run.
module radix2_fft_1024_core #(
   parameter int POINTS       = 1024,
   parameter int INPUT_BITS   = 16,
   parameter int TWIDDLE_BITS = 16,
   localparam int ADDR_BITS   = $clog2(POINTS),
   localparam int WORK_BITS   = INPUT_BITS + ADDR_BITS + 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [1:0]                            req_cmd,
   input  logic [r2fft_pkg::INDEX_BITS-1:0]      req_index,
   input  logic signed [INPUT_BITS-1:0]          req_sample_real,
   input  logic signed [INPUT_BITS-1:0]          req_sample_imag,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [WORK_BITS-1:0]           rsp_result_real,
   output logic signed [WORK_BITS-1:0]           rsp_result_imag,
   output logic [r2fft_pkg::INDEX_BITS-1:0]      rsp_bin_number,
   output logic                                  rsp_is_done
);

   r2fft_pkg::job_ctrl_type           job_ctrl;
   logic [ADDR_BITS-1:0]              job_addr;
   logic signed [INPUT_BITS-1:0]      job_real;
   logic signed [INPUT_BITS-1:0]      job_imag;
   logic                              job_pop;
   logic                              out_full;
   r2fft_pkg::rsp_ctrl_type           rsp_ctrl;
   logic signed [WORK_BITS-1:0]       push_real;
   logic signed [WORK_BITS-1:0]       push_imag;
   logic [r2fft_pkg::INDEX_BITS-1:0]  push_bin;

   r2fft_front #(
      .INPUT_BITS (INPUT_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_index       (req_index),
      .req_sample_real (req_sample_real),
      .req_sample_imag (req_sample_imag),
      .job_ctrl        (job_ctrl),
      .job_addr        (job_addr),
      .job_real        (job_real),
      .job_imag        (job_imag),
      .job_pop         (job_pop)
   );

   r2fft_engine #(
      .POINTS       (POINTS),
      .INPUT_BITS   (INPUT_BITS),
      .TWIDDLE_BITS (TWIDDLE_BITS),
      .ADDR_BITS    (ADDR_BITS),
      .WORK_BITS    (WORK_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .job_ctrl  (job_ctrl),
      .job_addr  (job_addr),
      .job_real  (job_real),
      .job_imag  (job_imag),
      .job_pop   (job_pop),
      .out_full  (out_full),
      .rsp_ctrl  (rsp_ctrl),
      .push_real (push_real),
      .push_imag (push_imag),
      .push_bin  (push_bin)
   );

   r2fft_outq #(
      .WORK_BITS (WORK_BITS)
   ) u_outq (
      .clock           (clock),
      .reset           (reset),
      .rsp_ctrl        (rsp_ctrl),
      .push_real       (push_real),
      .push_imag       (push_imag),
      .push_bin        (push_bin),
      .out_full        (out_full),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_real (rsp_result_real),
      .rsp_result_imag (rsp_result_imag),
      .rsp_bin_number  (rsp_bin_number),
      .rsp_is_done     (rsp_is_done)
   );

endmodule

### tb/radix2_fft_1024_core_test.sv
module radix2_fft_1024_core_test;

   localparam int N = 1024;
   localparam int WB = 27;
   localparam int CYCLE_LIMIT = 1500000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic signed [WB-1:0] re;
      logic signed [WB-1:0] im;
      logic [9:0]           bin;
      logic                 done;
   } bin_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic [1:0] req_cmd = '0;
   logic [9:0] req_index = '0;
   logic signed [15:0] req_sample_real = '0;
   logic signed [15:0] req_sample_imag = '0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic signed [WB-1:0] rsp_result_real;
   logic signed [WB-1:0] rsp_result_imag;
   logic [9:0] rsp_bin_number;
   logic rsp_is_done;

   radix2_fft_1024_core uut (.*);

   always #5 clock = ~clock;

   // own copy of the work store and twiddle table
   logic signed [WB-1:0] bins_re[N];
   logic signed [WB-1:0] bins_im[N];
   longint tw_cos[N/2];
   longint tw_nsin[N/2];
   bin_result_type pending_bins[$];
   int errors = 0;
   int burst_left = 0;
   int cycles = 0;

   function automatic logic signed [WB-1:0] wrap27(longint v);
      return v[WB-1:0];
   endfunction

   // product rounded to nearest at 15 fraction bits
   function automatic longint round15(longint p);
      return (p + 64'sd16384) >>> 15;
   endfunction

   task automatic build_twiddles();
      real ang, c, s;
      longint rc, rs;
      for (int j = 0; j < N/2; j++) begin
         ang = 2.0 * 3.14159265358979323846 * j / N;
         c = $cos(ang);
         s = $sin(ang);
         rc = longint'($floor((c < 0 ? -c : c) * 32768.0 + 0.5));
         rs = longint'($floor(s * 32768.0 + 0.5));
         if (rc > 32767) rc = 32767;
         tw_cos[j] = (c < 0) ? -rc : rc;
         tw_nsin[j] = -rs;
      end
   endtask

   task automatic transform_bins();
      longint tr[N];
      longint ti[N];
      int r, a, b, k, stride;
      longint xr, xi, t_r, t_i, ar, ai;
      for (int i = 0; i < N; i++) begin
         r = 0;
         for (int q = 0; q < 10; q++) r = (r << 1) | ((i >> q) & 1);
         tr[i] = bins_re[r];
         ti[i] = bins_im[r];
      end
      for (int half = 1; half < N; half = half * 2) begin
         stride = N / (2 * half);
         for (int base = 0; base < N; base += 2 * half) begin
            for (int i = 0; i < half; i++) begin
               a = base + i;
               b = a + half;
               k = (i * stride) & (N/2 - 1);
               xr = tr[b];
               xi = ti[b];
               t_r = round15(xr * tw_cos[k] - xi * tw_nsin[k]);
               t_i = round15(xr * tw_nsin[k] + xi * tw_cos[k]);
               ar = tr[a];
               ai = ti[a];
               tr[b] = wrap27(ar - t_r);
               ti[b] = wrap27(ai - t_i);
               tr[a] = wrap27(ar + t_r);
               ti[a] = wrap27(ai + t_i);
            end
         end
      end
      for (int i = 0; i < N; i++) begin
         bins_re[i] = wrap27(tr[i]);
         bins_im[i] = wrap27(ti[i]);
      end
   endtask

   task automatic send_item(logic [1:0] c, logic [9:0] idx, logic signed [15:0] re,
                            logic signed [15:0] im);
      bin_result_type e;
      @(negedge clock);
      if (burst_left == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_push <= 1;
      req_cmd <= c;
      req_index <= idx;
      req_sample_real <= re;
      req_sample_imag <= im;
      do @(posedge clock); while (req_full);
      burst_left--;
      case (c)
         r2fft_pkg::CMD_LOAD: begin
            bins_re[idx] = re;
            bins_im[idx] = im;
         end
         r2fft_pkg::CMD_RUN: begin
            transform_bins();
            e = '{re: '0, im: '0, bin: '0, done: 1'b1};
            pending_bins.push_back(e);
         end
         r2fft_pkg::CMD_READ: begin
            e = '{re: bins_re[idx], im: bins_im[idx], bin: idx, done: 1'b0};
            pending_bins.push_back(e);
         end
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push <= 0;
      burst_left = 0;
      while (pending_bins.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'sd32767;
         2: return -16'sd32768;
         default: return 16'($signed($urandom_range(0, 255)) - 128);
      endcase
   endfunction

   task automatic test_extremes();
      for (int i = 0; i < N; i++)
         send_item(r2fft_pkg::CMD_LOAD, 10'(i), (i % 2) ? -16'sd32768 : 16'sd32767,
                   (i % 3) ? 16'sd32767 : -16'sd32768);
      // read before run returns the loaded sample
      send_item(r2fft_pkg::CMD_READ, 10'd0, '0, '0);
      send_item(r2fft_pkg::CMD_READ, 10'd1023, '0, '0);
      send_item(CMD_UNUSED, 10'd1023, 16'sd32767, -16'sd32768);
      send_item(CMD_UNUSED, 10'd0, '0, '0);
      send_item(r2fft_pkg::CMD_RUN, 10'd0, '0, '0);
      send_item(r2fft_pkg::CMD_READ, 10'd0, '0, '0);
      send_item(r2fft_pkg::CMD_READ, 10'd512, '0, '0);
      send_item(r2fft_pkg::CMD_READ, 10'd1023, '0, '0);
      // second run on top of the transformed store
      send_item(r2fft_pkg::CMD_RUN, 10'd0, '0, '0);
      send_item(r2fft_pkg::CMD_READ, 10'd0, '0, '0);
      send_item(r2fft_pkg::CMD_READ, 10'd1023, '0, '0);
   endtask

   task automatic test_random_mix(int count);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2)
            send_item(r2fft_pkg::CMD_RUN, 10'($urandom), 16'($urandom), 16'($urandom));
         case ($urandom_range(0, 9))
            0, 1, 2: send_item(r2fft_pkg::CMD_LOAD, 10'($urandom), rand_sample(),
                               rand_sample());
            3: send_item(CMD_UNUSED, 10'($urandom), 16'($urandom), 16'($urandom));
            default: send_item(r2fft_pkg::CMD_READ, 10'($urandom), 16'($urandom),
                               16'($urandom));
         endcase
      end
   endtask

   task automatic test_drain_pause();
      for (int n = 0; n < 20; n++) send_item(r2fft_pkg::CMD_READ, 10'($urandom), '0, '0);
      wait_drained();
      repeat ($urandom_range(5, 30)) @(negedge clock);
      for (int n = 0; n < 20; n++) send_item(r2fft_pkg::CMD_READ, 10'($urandom), '0, '0);
   endtask

   // receiver with its own stall pattern, sometimes long clear stretches
   int stall_left = 0;
   int free_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 0;
      end else if (free_left > 0) begin
         free_left--;
         rsp_pop <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_pop <= 0;
      end else begin
         rsp_pop <= 1;
         case ($urandom_range(0, 9))
            0: free_left = $urandom_range(20, 200);
            1, 2: stall_left = $urandom_range(1, 25);
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      bin_result_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_bins.size() == 0) begin
            $error("unexpected item: bin %0d done %0d", rsp_bin_number, rsp_is_done);
            errors++;
         end else begin
            e = pending_bins.pop_front();
            if (rsp_result_real !== e.re) begin
               $error("result_real: expected %0d actual %0d", e.re, rsp_result_real);
               errors++;
            end
            if (rsp_result_imag !== e.im) begin
               $error("result_imag: expected %0d actual %0d", e.im, rsp_result_imag);
               errors++;
            end
            if (rsp_bin_number !== e.bin) begin
               $error("bin_number: expected %0d actual %0d", e.bin, rsp_bin_number);
               errors++;
            end
            if (rsp_is_done !== e.done) begin
               $error("is_done: expected %0d actual %0d", e.done, rsp_is_done);
               errors++;
            end
         end
      end
   end

   initial begin
      build_twiddles();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_extremes();
      test_drain_pause();
      test_random_mix(160);
      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0 && pending_bins.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
